// File: rtl/core/leqt_pkg.sv
// ----------------------------------------------------------------------------
// leqt_pkg: shared types and constants of the label equivalence table
// Field layouts of the request and result transactions, the table entry,
// the memory request bundle and the operation codes.
// ----------------------------------------------------------------------------
package leqt_pkg;

  localparam int LABEL_W         = 12;
  localparam int TABLE_DEPTH     = 2 ** LABEL_W;
  localparam int NUM_LABELS_DEF  = 4096;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_RESOLVE = 2'd1;
  localparam logic [1:0] OP_FLATTEN = 2'd2;

  typedef logic [LABEL_W-1:0] label_t;

  typedef struct packed {
    logic [1:0] operation;
    label_t     label_a;
    label_t     label_b;
  } in_item_t;

  typedef struct packed {
    logic   accepted;
    label_t resolved_label;
    logic   walk_overflow;
  } out_item_t;

  // one table word: valid flag plus the equivalent label
  typedef struct packed {
    logic   valid;
    label_t target;
  } entry_t;

  typedef struct packed {
    logic   rd_en;
    label_t rd_addr;
    logic   wr_en;
    label_t wr_addr;
    entry_t wr_data;
  } mem_req_t;

endpackage

// File: rtl/core/leqt_mem.sv
// ----------------------------------------------------------------------------
// leqt_mem: label table storage
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module leqt_mem
  import leqt_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd_data
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// File: rtl/core/leqt_seq.sv
// ----------------------------------------------------------------------------
// leqt_seq: operation sequencer
// Clearing pass, add read-modify-write, chain walks for resolve and flatten.
// One hop per cycle: the registered read data steers the next read address.
// ----------------------------------------------------------------------------
module leqt_seq
  import leqt_pkg::*;
#(
  parameter int NUM_LABELS = NUM_LABELS_DEF
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_item_t  item,
  input  logic      slot_free,
  output logic      done,
  output out_item_t done_item,
  output mem_req_t  req,
  input  entry_t    rd_data
);

  localparam int HOP_W = $clog2(NUM_LABELS + 1);
  localparam logic [HOP_W-1:0] HOP_MAX = HOP_W'(NUM_LABELS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD,
    S_WALK,
    S_DONE
  } state_t;

  state_t       state;
  logic [1:0]   op;
  label_t       start;
  label_t       cur;
  label_t       prev;
  label_t       lbl;
  label_t       tgt_b;
  label_t       clr_addr;
  logic [HOP_W-1:0] hops;
  logic         ovf;
  out_item_t    res;

  // walk step decode on the registered read data
  logic   step_end;
  label_t step_lbl;
  logic   step_ovf;
  logic   fl_write;
  logic   fl_last;
  logic   add_ok;

  assign item_stall = (state != S_IDLE);
  assign done       = (state == S_DONE) && slot_free;
  assign done_item  = res;
  assign fl_write   = !((hops == '0) && !rd_data.valid);
  assign fl_last    = (lbl == '1);
  assign add_ok     = (start != tgt_b) && !rd_data.valid;

  always_comb begin
    step_end = 1'b1;
    step_lbl = cur;
    step_ovf = 1'b0;
    if (!rd_data.valid) begin
      step_lbl = cur;
    end else if (hops == HOP_MAX) begin
      step_ovf = 1'b1;
    end else if (rd_data.target == start) begin
      step_lbl = prev;
    end else begin
      step_end = 1'b0;
    end
  end

  always_comb begin
    req = '0;
    unique case (state)
      S_CLEAR: begin
        req.wr_en   = 1'b1;
        req.wr_addr = clr_addr;
      end
      S_IDLE: begin
        req.rd_en   = item_valid;
        req.rd_addr = (item.operation == OP_FLATTEN) ? '0 : item.label_a;
      end
      S_ADD: begin
        req.wr_en   = add_ok;
        req.wr_addr = start;
        req.wr_data = '{valid: 1'b1, target: tgt_b};
      end
      S_WALK: begin
        if (!step_end) begin
          req.rd_en   = 1'b1;
          req.rd_addr = rd_data.target;
        end else if (op == OP_FLATTEN) begin
          req.wr_en   = fl_write;
          req.wr_addr = lbl;
          req.wr_data = '{valid: 1'b1, target: step_lbl};
          req.rd_en   = !fl_last;
          req.rd_addr = lbl + 1'b1;
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            op    <= item.operation;
            tgt_b <= item.label_b;
            hops  <= '0;
            ovf   <= 1'b0;
            lbl   <= '0;
            res   <= '0;
            if (item.operation == OP_FLATTEN) begin
              start <= '0;
              cur   <= '0;
              prev  <= '0;
            end else begin
              start <= item.label_a;
              cur   <= item.label_a;
              prev  <= item.label_a;
            end
            unique case (item.operation) inside
              OP_ADD:                 state <= S_ADD;
              OP_RESOLVE, OP_FLATTEN: state <= S_WALK;
              default:                state <= S_DONE;
            endcase
          end
        end
        S_ADD: begin
          res   <= '{accepted: add_ok, resolved_label: '0, walk_overflow: 1'b0};
          state <= S_DONE;
        end
        S_WALK: begin
          if (!step_end) begin
            cur  <= rd_data.target;
            prev <= rd_data.target;
            hops <= hops + 1'b1;
          end else if (op == OP_RESOLVE) begin
            res   <= '{accepted: 1'b0, resolved_label: step_lbl, walk_overflow: step_ovf};
            state <= S_DONE;
          end else begin
            ovf <= ovf | step_ovf;
            if (fl_last) begin
              res   <= '{accepted: 1'b0, resolved_label: '0,
                         walk_overflow: ovf | step_ovf};
              state <= S_DONE;
            end else begin
              lbl   <= lbl + 1'b1;
              start <= lbl + 1'b1;
              cur   <= lbl + 1'b1;
              prev  <= lbl + 1'b1;
              hops  <= '0;
            end
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/label_equivalence_table_top.sv
// ----------------------------------------------------------------------------
// label_equivalence_table_top: label equivalence table with chain resolve
// Maps each label to an equivalent label. Add stores a new entry, resolve
// follows a chain to its end, flatten rewrites every valid entry to its end label.
// ----------------------------------------------------------------------------
//
//   channel   handshake               payload
//   -------   ---------------------   ----------------------------------------
//   item      item_valid/item_stall   in_item_t: operation, label_a, label_b
//   result    result_valid/           out_item_t: accepted, resolved_label,
//             result_stall            walk_overflow
//
// Resolve follows one hop per cycle (bounded by the memory read loop),
// flatten walks the chain of every table entry in turn. One transaction
// at a time.
// Reset: a clearing pass writes every entry invalid; no item
// transaction is taken during it.
// Stalls: the result register holds a finished result while the next item
// transaction is accepted; a new result waits in the sequencer until the
// register frees.
// ----------------------------------------------------------------------------
module label_equivalence_table_top
  import leqt_pkg::*;
#(
  parameter int NUM_LABELS = NUM_LABELS_DEF
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  mem_req_t  req;
  entry_t    rd_data;
  logic      done;
  out_item_t done_item;
  logic      slot_free;

  // result register is free when empty or being drained this cycle
  assign slot_free = !result_valid || !result_stall;

  leqt_seq #(
    .NUM_LABELS (NUM_LABELS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .slot_free  (slot_free),
    .done       (done),
    .done_item  (done_item),
    .req        (req),
    .rd_data    (rd_data)
  );

  leqt_mem u_mem (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // output register: valid is registered, never a function of stall
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      result <= done_item;
    end
  end

endmodule
